// ===== rtl/epc_pkg.sv =====
// epc_pkg: shared constants, register and table codes, and the configuration
// struct of the eye pixel compositor
// no dependencies; compile before every other file of the block
package epc_pkg;

	// image geometry
	localparam int SCREEN_SIZE   = 128;
	localparam int SCLERA_SIZE   = 256;
	localparam int IRIS_SIZE     = 128;
	localparam int IRIS_MAP_COLS = 256;
	localparam int IRIS_MAP_ROWS = 64;

	localparam int LID_DEPTH    = SCREEN_SIZE * SCREEN_SIZE;
	localparam int SCLERA_DEPTH = SCLERA_SIZE * SCLERA_SIZE;
	localparam int POLAR_DEPTH  = IRIS_SIZE * IRIS_SIZE;
	localparam int TEX_DEPTH    = IRIS_MAP_COLS * IRIS_MAP_ROWS;

	localparam int LID_AW = $clog2(LID_DEPTH);
	localparam int SCL_AW = $clog2(SCLERA_DEPTH);
	localparam int POL_AW = $clog2(POLAR_DEPTH);
	localparam int TEX_AW = $clog2(TEX_DEPTH);
	localparam int TEX_RW = $clog2(IRIS_MAP_ROWS);
	localparam int TEX_CW = $clog2(IRIS_MAP_COLS);

	// window of the iris within the sclera
	localparam int IRIS_LO = (SCLERA_SIZE - IRIS_SIZE) / 2;
	localparam int IRIS_HI = IRIS_LO + IRIS_SIZE;

	// item field widths
	localparam int COORD_W = 7;
	localparam int ADDR_W  = 16;
	localparam int WORD_W  = 16;
	localparam int SEL_W   = 3;
	localparam int LID_W   = 8;
	localparam int SX_W    = 9;

	// polar word: low bits distance, high bits angle
	localparam int DIST_W      = 7;
	localparam int ANG_W       = WORD_W - DIST_W;
	localparam int ANG_FULL_SH = 9;

	// distance scaling: d = scale * dist / 240
	localparam int SCALE_W    = 10;
	localparam int PROD_W     = SCALE_W + DIST_W;
	localparam int DIST_DIV   = 240;
	localparam int D_LIMIT    = IRIS_MAP_ROWS * DIST_DIV;
	localparam int DP_W       = $clog2(D_LIMIT);
	localparam int RECIP_SH   = 24;
	localparam int RECIP      = ((1 << RECIP_SH) + DIST_DIV - 1) / DIST_DIV;
	localparam int RECIP_W    = $clog2(RECIP + 1);
	localparam int RP_W       = DP_W + RECIP_W;

	// item modes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_RENDER = 1'b1;

	// table codes
	localparam logic [SEL_W-1:0] TBL_LOWER_LID = 3'd0;
	localparam logic [SEL_W-1:0] TBL_UPPER_LID = 3'd1;
	localparam logic [SEL_W-1:0] TBL_SCLERA    = 3'd2;
	localparam logic [SEL_W-1:0] TBL_POLAR     = 3'd3;
	localparam logic [SEL_W-1:0] TBL_IRIS_TEX  = 3'd4;

	// configuration registers
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_IRIS_SCALE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCLERA_X_OFFSET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCLERA_Y_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LID_UNMIRRORED  = 3'd5;

	typedef struct packed {
		logic [SCALE_W-1:0] iris_scale;
		logic [7:0]         sclera_x_offset;
		logic [7:0]         sclera_y_offset;
		logic [LID_W-1:0]   upper_threshold;
		logic [LID_W-1:0]   lower_threshold;
		logic               lid_unmirrored;
	} epc_cfg_t;

endpackage

// ===== rtl/epc_if.sv =====
// epc_item_if and epc_pixel_if: valid/ready channels of the compositor,
// one carrying load and render words in, one carrying pixels out
// depends on epc_pkg
interface epc_item_if
	import epc_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [SEL_W-1:0]   table_select;
	logic [ADDR_W-1:0]  load_address;
	logic [WORD_W-1:0]  load_data;
	logic [COORD_W-1:0] screen_x;
	logic [COORD_W-1:0] screen_y;

	modport source (
		output valid, mode, table_select, load_address, load_data, screen_x, screen_y,
		input  ready
	);
	modport sink (
		input  valid, mode, table_select, load_address, load_data, screen_x, screen_y,
		output ready
	);
endinterface

interface epc_pixel_if
	import epc_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] pixel;

	modport source (output valid, pixel, input ready);
	modport sink (input valid, pixel, output ready);
endinterface

// ===== rtl/epc_cfg_regs.sv =====
// epc_cfg_regs: configuration register file of the compositor, decodes the
// write port and holds the registers with their reset values
// depends on epc_pkg
module epc_cfg_regs
	import epc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output epc_cfg_t              cfg
);

	epc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iris_scale      <= SCALE_W'(512);
			cfg_q.sclera_x_offset <= 8'd64;
			cfg_q.sclera_y_offset <= 8'd64;
			cfg_q.upper_threshold <= '0;
			cfg_q.lower_threshold <= '0;
			cfg_q.lid_unmirrored  <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_IRIS_SCALE:      cfg_q.iris_scale      <= wr_data[SCALE_W-1:0];
				REG_SCLERA_X_OFFSET: cfg_q.sclera_x_offset <= wr_data[7:0];
				REG_SCLERA_Y_OFFSET: cfg_q.sclera_y_offset <= wr_data[7:0];
				REG_UPPER_THRESHOLD: cfg_q.upper_threshold <= wr_data[LID_W-1:0];
				REG_LOWER_THRESHOLD: cfg_q.lower_threshold <= wr_data[LID_W-1:0];
				REG_LID_UNMIRRORED:  cfg_q.lid_unmirrored  <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/eye_pixel_compositor.sv =====
// eye_pixel_compositor: top level, five image stores and the render pipeline
// depends on epc_pkg, epc_if (channel interfaces) and epc_cfg_regs
//
// One word is taken per clock while the input is ready, load or render alike,
// and a render word's pixel passes stages 1 to 3 and the output register. The
// lid maps, sclera image and polar map are read in the cycle a word is taken;
// the iris texture is read two stages later, once the polar distance has been
// scaled, and texture loads travel the pipeline to that same stage so that
// loads and renders keep their order on every store. Stages close up bubbles,
// so the input stays ready until all four stages hold words and the output is
// stalled. Stores come up undefined and need no clearing after reset; a render
// must only touch entries already loaded. The user must write configuration only
// while no word is in flight; the block itself does not enforce it.
module eye_pixel_compositor
	import epc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	epc_item_if.sink              item,
	epc_pixel_if.source           result
);

	epc_cfg_t cfg;

	epc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// stores
	logic [LID_W-1:0]  lo_mem  [LID_DEPTH];
	logic [LID_W-1:0]  up_mem  [LID_DEPTH];
	logic [WORD_W-1:0] scl_mem [SCLERA_DEPTH];
	logic [WORD_W-1:0] pol_mem [POLAR_DEPTH];
	logic [WORD_W-1:0] tex_mem [TEX_DEPTH];

	// flow control
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic accept;

	assign rdy_out    = !out_valid_q || result.ready;
	assign rdy_s3     = !valid_s3 || rdy_out;
	assign rdy_s2     = !valid_s2 || rdy_s3;
	assign rdy_s1     = !valid_s1 || rdy_s2;
	assign item.ready = rdy_s1;
	assign accept     = item.valid && rdy_s1;

	// address generation on the incoming word
	logic               is_render;
	logic [COORD_W-1:0] lx;
	logic [LID_AW-1:0]  lid_addr;
	logic [SX_W-1:0]    sx, sy, ix, iy;
	logic [SCL_AW-1:0]  scl_addr;
	logic [POL_AW-1:0]  pol_addr;
	logic               scr_ok, scl_ok, win;
	logic               lo_we, up_we, scl_we, pol_we, tex_ld;

	always_comb begin
		is_render = item.mode == MODE_RENDER;
		scr_ok    = (32'(item.screen_x) < SCREEN_SIZE) && (32'(item.screen_y) < SCREEN_SIZE);
		// first eye uses the lid maps mirrored left to right
		lx        = cfg.lid_unmirrored ? item.screen_x
		                               : COORD_W'(SCREEN_SIZE - 1 - 32'(item.screen_x));
		lid_addr  = LID_AW'(32'(item.screen_y) * SCREEN_SIZE + 32'(lx));
		sx        = SX_W'(cfg.sclera_x_offset) + SX_W'(item.screen_x);
		sy        = SX_W'(cfg.sclera_y_offset) + SX_W'(item.screen_y);
		scl_ok    = (32'(sx) < SCLERA_SIZE) && (32'(sy) < SCLERA_SIZE);
		scl_addr  = SCL_AW'(32'(sy) * SCLERA_SIZE + 32'(sx));
		win       = (32'(sx) >= IRIS_LO) && (32'(sx) < IRIS_HI) &&
		            (32'(sy) >= IRIS_LO) && (32'(sy) < IRIS_HI);
		ix        = sx - SX_W'(IRIS_LO);
		iy        = sy - SX_W'(IRIS_LO);
		pol_addr  = POL_AW'(32'(iy) * IRIS_SIZE + 32'(ix));

		lo_we  = 1'b0;
		up_we  = 1'b0;
		scl_we = 1'b0;
		pol_we = 1'b0;
		tex_ld = 1'b0;
		if (!is_render) begin
			case (item.table_select)
				TBL_LOWER_LID: lo_we  = 32'(item.load_address) < LID_DEPTH;
				TBL_UPPER_LID: up_we  = 32'(item.load_address) < LID_DEPTH;
				TBL_SCLERA:    scl_we = 32'(item.load_address) < SCLERA_DEPTH;
				TBL_POLAR:     pol_we = 32'(item.load_address) < POLAR_DEPTH;
				TBL_IRIS_TEX:  tex_ld = 32'(item.load_address) < TEX_DEPTH;
				default: ;
			endcase
		end
	end

	// first stage stores: written by loads, read by renders as they are taken
	logic [LID_W-1:0]  lo_rd_s1, up_rd_s1;
	logic [WORD_W-1:0] scl_rd_s1, pol_rd_s1;
	logic              rd_en;

	assign rd_en = accept && is_render;

	always_ff @(posedge clk) begin
		if (accept && lo_we)
			lo_mem[item.load_address[LID_AW-1:0]] <= item.load_data[LID_W-1:0];
		if (rd_en)
			lo_rd_s1 <= lo_mem[lid_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && up_we)
			up_mem[item.load_address[LID_AW-1:0]] <= item.load_data[LID_W-1:0];
		if (rd_en)
			up_rd_s1 <= up_mem[lid_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && scl_we)
			scl_mem[item.load_address[SCL_AW-1:0]] <= item.load_data;
		if (rd_en)
			scl_rd_s1 <= scl_mem[scl_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && pol_we)
			pol_mem[item.load_address[POL_AW-1:0]] <= item.load_data;
		if (rd_en)
			pol_rd_s1 <= pol_mem[pol_addr];
	end

	// stage 1
	logic              render_s1, scr_ok_s1, scl_ok_s1, win_s1, tex_we_s1;
	logic [TEX_AW-1:0] tex_addr_s1;
	logic [WORD_W-1:0] tex_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			render_s1   <= is_render;
			scr_ok_s1   <= scr_ok;
			scl_ok_s1   <= scl_ok;
			win_s1      <= win;
			tex_we_s1   <= tex_ld;
			tex_addr_s1 <= item.load_address[TEX_AW-1:0];
			tex_data_s1 <= item.load_data;
		end
	end

	// stage 2: lid test and distance times scale
	logic              render_s2, covered_s2, win_s2, tex_we_s2;
	logic [WORD_W-1:0] scl_pix_s2, tex_data_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [ANG_W-1:0]  angle_s2;
	logic [TEX_AW-1:0] tex_addr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			render_s2   <= render_s1;
			covered_s2  <= !scr_ok_s1 || (lo_rd_s1 <= cfg.lower_threshold) ||
			               (up_rd_s1 <= cfg.upper_threshold);
			win_s2      <= win_s1;
			scl_pix_s2  <= scl_ok_s1 ? scl_rd_s1 : '0;
			prod_s2     <= PROD_W'(cfg.iris_scale) * PROD_W'(pol_rd_s1[DIST_W-1:0]);
			angle_s2    <= pol_rd_s1[WORD_W-1:DIST_W];
			tex_we_s2   <= tex_we_s1;
			tex_addr_s2 <= tex_addr_s1;
			tex_data_s2 <= tex_data_s1;
		end
	end

	// divide by 240 through a reciprocal, exact below the texture height limit
	logic              d_ok;
	logic [RP_W-1:0]   recip_prod;
	logic [TEX_RW-1:0] tex_row;
	logic [TEX_CW-1:0] tex_col;
	logic [TEX_AW-1:0] tex_rd_addr;
	logic              tex_re, tex_we;

	always_comb begin
		d_ok        = 32'(prod_s2) < D_LIMIT;
		recip_prod  = RP_W'(prod_s2[DP_W-1:0]) * RP_W'(RECIP);
		tex_row     = TEX_RW'(recip_prod >> RECIP_SH);
		tex_col     = TEX_CW'((32'(angle_s2) * IRIS_MAP_COLS) >> ANG_FULL_SH);
		tex_rd_addr = TEX_AW'(32'(tex_row) * IRIS_MAP_COLS + 32'(tex_col));
		tex_re      = rdy_s3 && valid_s2 && render_s2;
		tex_we      = rdy_s3 && valid_s2 && !render_s2 && tex_we_s2;
	end

	// texture store, accessed where words leave stage 2 so order is kept
	logic [WORD_W-1:0] tex_rd_s3;

	always_ff @(posedge clk) begin
		if (tex_we)
			tex_mem[tex_addr_s2] <= tex_data_s2;
		if (tex_re)
			tex_rd_s3 <= tex_mem[tex_rd_addr];
	end

	// stage 3
	logic              covered_s3, use_tex_s3;
	logic [WORD_W-1:0] scl_pix_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			// loads end here
			valid_s3 <= valid_s2 && render_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			covered_s3 <= covered_s2;
			use_tex_s3 <= win_s2 && d_ok;
			scl_pix_s3 <= scl_pix_s2;
		end
	end

	// output register, bytes swapped
	logic [WORD_W-1:0] pix;
	logic [WORD_W-1:0] pixel_q;

	always_comb begin
		pix = use_tex_s3 ? tex_rd_s3 : scl_pix_s3;
		if (covered_s3)
			pix = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out)
			pixel_q <= {pix[7:0], pix[15:8]};
	end

	assign result.valid = out_valid_q;
	assign result.pixel = pixel_q;

`ifndef ASSERT_OFF
	// input only blocks when every stage is full behind a stalled output
	a_ready_low_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (valid_s1 && valid_s2 && valid_s3 && out_valid_q && !result.ready))
		else $error("input stalled with a free stage");

	// a covered pixel leaves as black
	a_covered_black: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy_out && valid_s3 && covered_s3) |=> (result.valid && result.pixel == '0))
		else $error("covered pixel not black");

	// a load word never turns into a pixel
	a_load_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy_s3 && valid_s2 && !render_s2) |=> !valid_s3)
		else $error("load word reached output stage");

	// the texture is only used inside the iris window
	a_tex_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(rdy_s3 && valid_s2 && !win_s2) |=> !use_tex_s3)
		else $error("texture picked outside iris window");
`endif

endmodule

// ===== verif/epc_pixel_check.sv =====
`timescale 1ns / 100ps
// epc_pixel_check: watches the item and pixel channels of the compositor,
// predicts every pixel from its own copy of the stores and registers, compares
// depends on epc_pkg and epc_if
module epc_pixel_check
	import epc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	epc_item_if                   item,
	epc_pixel_if                  result,
	output int                    mismatches,
	output int                    pending
);

	logic [LID_W-1:0]  lower_lid  [LID_DEPTH];
	logic [LID_W-1:0]  upper_lid  [LID_DEPTH];
	logic [WORD_W-1:0] sclera_img [SCLERA_DEPTH];
	logic [WORD_W-1:0] polar      [POLAR_DEPTH];
	logic [WORD_W-1:0] iris_tex   [TEX_DEPTH];
	epc_cfg_t          cfg;
	logic [WORD_W-1:0] expected_pixels [$];
	logic [WORD_W-1:0] want;
	int                fail_count = 0;

	assign mismatches = fail_count;

	function automatic logic [WORD_W-1:0] sclera_at(input int sx, input int sy);
		if (sx >= SCLERA_SIZE || sy >= SCLERA_SIZE)
			return '0;
		return sclera_img[sy * SCLERA_SIZE + sx];
	endfunction

	function automatic logic [WORD_W-1:0] composite_pixel(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		int lx, li, sx, sy, ix, iy, d, a;
		logic [WORD_W-1:0] w, p;
		if (int'(x) >= SCREEN_SIZE || int'(y) >= SCREEN_SIZE)
			return '0;
		lx = cfg.lid_unmirrored ? int'(x) : SCREEN_SIZE - 1 - int'(x);
		li = int'(y) * SCREEN_SIZE + lx;
		if (lower_lid[li] <= cfg.lower_threshold || upper_lid[li] <= cfg.upper_threshold)
			return '0;
		sx = int'(cfg.sclera_x_offset) + int'(x);
		sy = int'(cfg.sclera_y_offset) + int'(y);
		ix = sx - IRIS_LO;
		iy = sy - IRIS_LO;
		if (ix < 0 || ix >= IRIS_SIZE || iy < 0 || iy >= IRIS_SIZE) begin
			p = sclera_at(sx, sy);
		end else begin
			w = polar[iy * IRIS_SIZE + ix];
			d = int'(cfg.iris_scale) * int'(w[DIST_W-1:0]) / DIST_DIV;
			if (d < IRIS_MAP_ROWS) begin
				// angle spans the full texture width
				a = IRIS_MAP_COLS * int'(w[WORD_W-1:DIST_W]) / (1 << ANG_FULL_SH);
				p = iris_tex[d * IRIS_MAP_COLS + a];
			end else begin
				p = sclera_at(sx, sy);
			end
		end
		return {p[7:0], p[15:8]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{10'd512, 8'd64, 8'd64, 8'd0, 8'd0, 1'b0};
			expected_pixels.delete();
			pending <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel: no word expected, got %h", result.pixel);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (result.pixel !== want) begin
						$error("pixel: expected %h, got %h", want, result.pixel);
						fail_count++;
					end
				end
			end
			if (item.valid && item.ready) begin
				if (item.mode == MODE_RENDER) begin
					expected_pixels.push_back(composite_pixel(item.screen_x, item.screen_y));
				end else begin
					case (item.table_select)
					TBL_LOWER_LID: if (item.load_address < LID_DEPTH)
						lower_lid[item.load_address[LID_AW-1:0]] = item.load_data[LID_W-1:0];
					TBL_UPPER_LID: if (item.load_address < LID_DEPTH)
						upper_lid[item.load_address[LID_AW-1:0]] = item.load_data[LID_W-1:0];
					TBL_SCLERA: sclera_img[item.load_address[SCL_AW-1:0]] = item.load_data;
					TBL_POLAR: if (item.load_address < POLAR_DEPTH)
						polar[item.load_address[POL_AW-1:0]] = item.load_data;
					TBL_IRIS_TEX: if (item.load_address < TEX_DEPTH)
						iris_tex[item.load_address[TEX_AW-1:0]] = item.load_data;
					default: ;
					endcase
				end
			end
			if (wr_en) begin
				case (wr_index)
				REG_IRIS_SCALE:      cfg.iris_scale = wr_data[SCALE_W-1:0];
				REG_SCLERA_X_OFFSET: cfg.sclera_x_offset = wr_data[7:0];
				REG_SCLERA_Y_OFFSET: cfg.sclera_y_offset = wr_data[7:0];
				REG_UPPER_THRESHOLD: cfg.upper_threshold = wr_data[LID_W-1:0];
				REG_LOWER_THRESHOLD: cfg.lower_threshold = wr_data[LID_W-1:0];
				REG_LID_UNMIRRORED:  cfg.lid_unmirrored = wr_data[0];
				default: ;
				endcase
			end
			pending <= expected_pixels.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: stimulus and verdict for eye_pixel_compositor; loads the stores ahead of
// each render, sweeps register settings and idling, epc_pixel_check compares
// depends on epc_pkg, epc_if, epc_pixel_check and the block itself
module tb;
	import epc_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	int                    mismatches;
	int                    pending;
	int                    gap_pct = 0;
	int                    stall_pct = 0;
	int                    words_sent = 0;
	epc_cfg_t              settings;

	// which entries hold data, so no render touches an unloaded one
	bit                lower_done  [LID_DEPTH];
	bit                upper_done  [LID_DEPTH];
	bit                sclera_done [SCLERA_DEPTH];
	bit                polar_done  [POLAR_DEPTH];
	bit                tex_done    [TEX_DEPTH];
	logic [WORD_W-1:0] polar_copy  [POLAR_DEPTH];

	epc_item_if  item_ch ();
	epc_pixel_if pix_ch ();

	eye_pixel_compositor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.item     (item_ch.sink),
		.result   (pix_ch.source)
	);

	epc_pixel_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.item       (item_ch),
		.result     (pix_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		pix_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic push_word(input logic mode, input logic [SEL_W-1:0] sel,
			input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		while ($urandom_range(99) < gap_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.mode         <= mode;
		item_ch.table_select <= sel;
		item_ch.load_address <= addr;
		item_ch.load_data    <= data;
		item_ch.screen_x     <= x;
		item_ch.screen_y     <= y;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic load_word(input logic [SEL_W-1:0] sel, input logic [ADDR_W-1:0] addr,
			input logic [WORD_W-1:0] data);
		push_word(MODE_LOAD, sel, addr, data, COORD_W'($urandom), COORD_W'($urandom));
		case (sel)
		TBL_LOWER_LID: if (addr < LID_DEPTH) lower_done[addr] = 1'b1;
		TBL_UPPER_LID: if (addr < LID_DEPTH) upper_done[addr] = 1'b1;
		TBL_SCLERA:    sclera_done[addr] = 1'b1;
		TBL_POLAR: if (addr < POLAR_DEPTH) begin
			polar_done[addr] = 1'b1;
			polar_copy[addr] = data;
		end
		TBL_IRIS_TEX:  if (addr < TEX_DEPTH) tex_done[addr] = 1'b1;
		default: ;
		endcase
	endtask

	// lid value mostly above its threshold so that the eye shows through
	function automatic logic [WORD_W-1:0] lid_word(input logic [LID_W-1:0] thr);
		logic [LID_W-1:0] v;
		v = LID_W'($urandom);
		if (thr != '1 && $urandom_range(9) < 8)
			v = LID_W'($urandom_range(255, int'(thr) + 1));
		return {LID_W'($urandom), v};
	endfunction

	// loads whatever the pixel will read, then sends the render word
	task automatic render_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		int lx, li, sx, sy, ix, iy, pi, d, ti;
		logic [WORD_W-1:0] w;
		lx = settings.lid_unmirrored ? int'(x) : SCREEN_SIZE - 1 - int'(x);
		li = int'(y) * SCREEN_SIZE + lx;
		if (!lower_done[li])
			load_word(TBL_LOWER_LID, ADDR_W'(li), lid_word(settings.lower_threshold));
		if (!upper_done[li])
			load_word(TBL_UPPER_LID, ADDR_W'(li), lid_word(settings.upper_threshold));
		sx = int'(settings.sclera_x_offset) + int'(x);
		sy = int'(settings.sclera_y_offset) + int'(y);
		if (sx < SCLERA_SIZE && sy < SCLERA_SIZE) begin
			if (!sclera_done[sy * SCLERA_SIZE + sx])
				load_word(TBL_SCLERA, ADDR_W'(sy * SCLERA_SIZE + sx), WORD_W'($urandom));
		end
		ix = sx - IRIS_LO;
		iy = sy - IRIS_LO;
		if (ix >= 0 && ix < IRIS_SIZE && iy >= 0 && iy < IRIS_SIZE) begin
			pi = iy * IRIS_SIZE + ix;
			if (!polar_done[pi]) begin
				// short distances half the time so the texture is reached
				w[DIST_W-1:0] = ($urandom_range(1) == 0) ? DIST_W'($urandom_range(40))
					: DIST_W'($urandom);
				w[WORD_W-1:DIST_W] = ANG_W'($urandom);
				load_word(TBL_POLAR, ADDR_W'(pi), w);
			end
			w = polar_copy[pi];
			d = int'(settings.iris_scale) * int'(w[DIST_W-1:0]) / DIST_DIV;
			if (d < IRIS_MAP_ROWS) begin
				ti = d * IRIS_MAP_COLS
					+ IRIS_MAP_COLS * int'(w[WORD_W-1:DIST_W]) / (1 << ANG_FULL_SH);
				if (!tex_done[ti])
					load_word(TBL_IRIS_TEX, ADDR_W'(ti), WORD_W'($urandom));
			end
		end
		push_word(MODE_RENDER, SEL_W'($urandom), ADDR_W'($urandom), WORD_W'($urandom), x, y);
	endtask

	// waits until every pixel is out and the pipeline has emptied
	task automatic settle();
		item_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
		wr_index <= idx;
		wr_data  <= CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	task automatic apply_settings(input epc_cfg_t s);
		wr_en <= 1'b1;
		reg_write(REG_IRIS_SCALE, s.iris_scale);
		reg_write(REG_SCLERA_X_OFFSET, s.sclera_x_offset);
		reg_write(REG_SCLERA_Y_OFFSET, s.sclera_y_offset);
		reg_write(REG_UPPER_THRESHOLD, s.upper_threshold);
		reg_write(REG_LOWER_THRESHOLD, s.lower_threshold);
		reg_write(REG_LID_UNMIRRORED, s.lid_unmirrored);
		wr_en <= 1'b0;
		@(posedge clk);
		settings = s;
	endtask

	initial begin
		int li, pi, target;
		epc_cfg_t next_cfg;
		arst_n               = 1'b0;
		wr_en                = 1'b0;
		wr_index             = '0;
		wr_data              = '0;
		item_ch.valid        = 1'b0;
		item_ch.mode         = MODE_LOAD;
		item_ch.table_select = '0;
		item_ch.load_address = '0;
		item_ch.load_data    = '0;
		item_ch.screen_x     = '0;
		item_ch.screen_y     = '0;
		pix_ch.ready         = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		next_cfg = '{10'd512, 8'd64, 8'd64, 8'd0, 8'd0, 1'b0};
		apply_settings(next_cfg);

		// screen corners with mirrored lids
		render_pixel(0, 0);
		render_pixel(COORD_W'(SCREEN_SIZE - 1), COORD_W'(SCREEN_SIZE - 1));
		render_pixel(0, COORD_W'(SCREEN_SIZE - 1));
		render_pixel(COORD_W'(SCREEN_SIZE - 1), 0);

		// polar extremes at one iris pixel: widest angle, beyond the rows, deep row
		pi = (9 + 64 - IRIS_LO) * IRIS_SIZE + (5 + 64 - IRIS_LO);
		load_word(TBL_POLAR, ADDR_W'(pi), {9'h1FF, 7'd0});
		render_pixel(5, 9);
		load_word(TBL_POLAR, ADDR_W'(pi), {9'h000, 7'h7F});
		render_pixel(5, 9);
		load_word(TBL_POLAR, ADDR_W'(pi), {9'h0AA, 7'd29});
		render_pixel(5, 9);

		// lid value equal to its threshold covers: lower lid first, then upper lid with the lower one above it
		li = 9 * SCREEN_SIZE + (SCREEN_SIZE - 1 - 5);
		load_word(TBL_LOWER_LID, ADDR_W'(li), 16'hFF00);
		render_pixel(5, 9);
		load_word(TBL_LOWER_LID, ADDR_W'(li), 16'h0001);
		load_word(TBL_UPPER_LID, ADDR_W'(li), 16'h0000);
		render_pixel(5, 9);
		load_word(TBL_UPPER_LID, ADDR_W'(li), 16'h00FF);

		// unknown tables and addresses past the end must leave the stores alone
		for (int k = 1; k <= 3; k++)
			load_word(TBL_IRIS_TEX + SEL_W'(k), ADDR_W'(li), 16'h0000);
		load_word(TBL_LOWER_LID, ADDR_W'(li + LID_DEPTH), 16'h0000);
		load_word(TBL_UPPER_LID, 16'hFFFF, 16'h0000);
		load_word(TBL_POLAR, ADDR_W'(pi + POLAR_DEPTH), 16'hFFFF);
		load_word(TBL_IRIS_TEX, ADDR_W'(TEX_DEPTH), 16'h0000);
		render_pixel(5, 9);
		settle();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
			0: next_cfg = '{10'd512, 8'd64, 8'd64, 8'd0, 8'd0, 1'b0};
			1: next_cfg = '{10'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1};
			2: next_cfg = '{10'd1023, 8'd128, 8'd128, 8'd255, 8'd255, 1'b1};
			3: next_cfg = '{10'd1023, 8'd128, 8'd0, 8'd0, 8'd0, 1'b0};
			default: begin
				next_cfg.iris_scale      = SCALE_W'($urandom_range(1023));
				next_cfg.sclera_x_offset = 8'($urandom_range(128));
				next_cfg.sclera_y_offset = 8'($urandom_range(128));
				next_cfg.upper_threshold = ($urandom_range(1) == 0) ? 8'($urandom_range(40))
					: 8'($urandom);
				next_cfg.lower_threshold = ($urandom_range(1) == 0) ? 8'($urandom_range(40))
					: 8'($urandom);
				next_cfg.lid_unmirrored  = 1'($urandom);
			end
			endcase
			apply_settings(next_cfg);
			case (ph % 4)
			0: begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct   = 83;
				stall_pct = 0;
			end
			2: begin
				gap_pct   = 0;
				stall_pct = 83;
			end
			default: begin
				gap_pct   = 12;
				stall_pct = 12;
			end
			endcase
			target = words_sent + 150;
			while (words_sent < target) begin
				if ($urandom_range(99) < 75) begin
					// half the renders stay in one corner so entries get reused
					if ($urandom_range(1) == 0)
						render_pixel(COORD_W'($urandom_range(15)), COORD_W'($urandom_range(15)));
					else
						render_pixel(COORD_W'($urandom), COORD_W'($urandom));
				end else begin
					load_word(SEL_W'($urandom), ADDR_W'($urandom), WORD_W'($urandom));
				end
			end
			settle();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
